[sv/max_tracking_stack_assert.svh]
// assertion macros used by the stack top level design file
`ifndef MAX_TRACKING_STACK_ASSERT_SVH
`define MAX_TRACKING_STACK_ASSERT_SVH

// condition holds in the same cycle as its trigger
`define MTS_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after its trigger
`define MTS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[sv/mts_pkg.sv]
// shared constants and types for the max tracking stack
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_POP_EMPTY = 2'd1,
    ERR_PUSH_FULL = 2'd2
  } err_t;

  typedef struct packed {
    data_t popped_value;
    data_t current_max;
    logic  max_valid;
    logic  is_empty;
    err_t  error_code;
  } result_t;

endpackage

[sv/mts_out_buf.sv]
// two-entry result buffer: output register plus skid register
module mts_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            word_valid,
  input  mts_pkg::result_t word,
  output logic            full,
  output logic            out_valid,
  output mts_pkg::result_t out_word,
  input  logic            out_stall
);
  import mts_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_word;
  result_t skid_word;
  logic    main_taken;

  assign main_taken = main_valid && !out_stall;
  assign full       = skid_valid;
  assign out_valid  = main_valid;
  assign out_word   = main_word;

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (main_taken) begin
        skid_valid <= 1'b0;
      end
    end else if (word_valid) begin
      if (main_valid && !main_taken) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (main_taken) begin
      main_valid <= 1'b0;
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (main_taken) begin
        main_word <= skid_word;
      end
    end else if (word_valid) begin
      if (main_valid && !main_taken) begin
        skid_word <= word;
      end else begin
        main_word <= word;
      end
    end
  end

endmodule

[sv/max_tracking_stack.sv]
// max tracking stack top level: value and maxima stacks with result buffer
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, operation, push_value | into block
//  out     | out_valid, out_stall, popped_value,       | out of block
//          | current_max, max_valid, is_empty,         |
//          | error_code                                |
//
// one word per cycle while in_stall is low: each push or pop is resolved in the
// accept cycle against top registers, and the result lands in the output buffer.
// the next-below entries of both stacks are prefetched through one
// registered read port per memory, so back to back pops run at full rate.
// synchronous reset empties both stacks; no clearing pass is needed.
// in_stall rises only when both output buffer entries are full.
`include "max_tracking_stack_assert.svh"

module max_tracking_stack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  mts_pkg::data_t        push_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mts_pkg::data_t        popped_value,
  output mts_pkg::data_t        current_max,
  output logic                  max_valid,
  output logic                  is_empty,
  output logic [1:0]            error_code
);
  import mts_pkg::*;

  // stack memories
  data_t value_mem [STACK_DEPTH];
  data_t max_mem   [STACK_DEPTH];

  // counts and cached tops
  count_t value_count, value_count_next;
  count_t max_count, max_count_next;
  data_t  top_value, top_value_next;
  data_t  max_top, max_top_next;
  data_t  value_below;
  data_t  max_below;

  logic    accept;
  logic    value_we;
  logic    max_we;
  logic    buf_full;
  count_t  value_rd_sum;
  count_t  max_rd_sum;
  addr_t   value_rd_addr;
  addr_t   max_rd_addr;
  result_t res;
  result_t res_out;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // one push or pop against the cached tops
  always_comb begin
    value_count_next = value_count;
    max_count_next   = max_count;
    top_value_next   = top_value;
    max_top_next     = max_top;
    value_we         = 1'b0;
    max_we           = 1'b0;
    res.popped_value = '0;
    res.error_code   = ERR_OK;
    if (accept) begin
      if (operation == OP_PUSH) begin
        if (value_count == count_t'(STACK_DEPTH)) begin
          res.error_code = ERR_PUSH_FULL;
        end else begin
          value_we         = 1'b1;
          value_count_next = value_count + count_t'(1);
          top_value_next   = push_value;
          if (max_count == '0 || push_value >= max_top) begin
            max_we         = 1'b1;
            max_count_next = max_count + count_t'(1);
            max_top_next   = push_value;
          end
        end
      end else begin
        if (value_count == '0) begin
          res.error_code = ERR_POP_EMPTY;
        end else begin
          res.popped_value = top_value;
          value_count_next = value_count - count_t'(1);
          top_value_next   = value_below;
          if (max_count != '0 && top_value == max_top) begin
            max_count_next = max_count - count_t'(1);
            max_top_next   = max_below;
          end
        end
      end
    end
    res.max_valid   = (value_count_next != '0) && (max_count_next != '0);
    res.current_max = res.max_valid ? max_top_next : '0;
    res.is_empty    = (value_count_next == '0);
  end

  // prefetch addresses: entry just below the new top
  assign value_rd_sum  = value_count_next - count_t'(2);
  assign max_rd_sum    = max_count_next - count_t'(2);
  assign value_rd_addr = value_rd_sum[ADDR_W-1:0];
  assign max_rd_addr   = max_rd_sum[ADDR_W-1:0];

  // value stack memory
  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_count[ADDR_W-1:0]] <= push_value;
    end
    value_below <= value_mem[value_rd_addr];
  end

  // maxima stack memory
  always_ff @(posedge clk) begin
    if (max_we) begin
      max_mem[max_count[ADDR_W-1:0]] <= push_value;
    end
    max_below <= max_mem[max_rd_addr];
  end

  // counts
  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
      max_count   <= '0;
    end else begin
      value_count <= value_count_next;
      max_count   <= max_count_next;
    end
  end

  // cached tops
  always_ff @(posedge clk) begin
    top_value <= top_value_next;
    max_top   <= max_top_next;
  end

  mts_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .word_valid (accept),
    .word       (res),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_word   (res_out),
    .out_stall  (out_stall)
  );

  assign popped_value = res_out.popped_value;
  assign current_max  = res_out.current_max;
  assign max_valid    = res_out.max_valid;
  assign is_empty     = res_out.is_empty;
  assign error_code   = res_out.error_code;

  // checks
  `MTS_ASSERT_NOW(a_max_count_bound, 1'b1, max_count <= value_count, "maxima count exceeds value count")
  `MTS_ASSERT_NOW(a_count_bound, 1'b1, value_count <= count_t'(STACK_DEPTH), "value count beyond depth")
  `MTS_ASSERT_NOW(a_max_dominates, value_count != '0 && max_count != '0, max_top >= top_value, "cached maximum below top value")
  `MTS_ASSERT_NEXT(a_pop_count, accept && operation == OP_POP && value_count != '0, value_count == $past(value_count) - count_t'(1), "pop did not lower the count")

endmodule

[dv/max_tracking_stack_check.sv]
`timescale 1ns / 1ps
// scoreboard for the max tracking stack: predicts every result word and checks it
module max_tracking_stack_check (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  logic           operation,
  input  mts_pkg::data_t push_value,
  input  logic           out_valid,
  input  logic           out_stall,
  input  mts_pkg::data_t popped_value,
  input  mts_pkg::data_t current_max,
  input  logic           max_valid,
  input  logic           is_empty,
  input  logic [1:0]     error_code,
  output int             fail_count,
  output int             pending
);
  import mts_pkg::*;

  // shadow copy of both stacks
  data_t   value_mem [STACK_DEPTH];
  data_t   peak_mem [STACK_DEPTH];
  int      value_depth = 0;
  int      peak_depth = 0;
  result_t result_q[$];
  int      mismatches = 0;

  assign fail_count = mismatches;

  // apply one push or pop to the shadow stacks and build the result word
  function automatic result_t next_result(input logic op, input data_t word_value);
    result_t r;
    r.popped_value = '0;
    r.error_code   = ERR_OK;
    if (op == OP_PUSH) begin
      if (value_depth >= STACK_DEPTH) begin
        r.error_code = ERR_PUSH_FULL;
      end else begin
        value_mem[value_depth] = word_value;
        value_depth++;
        // a value at or above the running peak becomes the new peak
        if (peak_depth == 0 || word_value >= peak_mem[peak_depth-1]) begin
          if (peak_depth < STACK_DEPTH) begin
            peak_mem[peak_depth] = word_value;
            peak_depth++;
          end
        end
      end
    end else begin
      if (value_depth == 0) begin
        r.error_code = ERR_POP_EMPTY;
      end else begin
        value_depth--;
        r.popped_value = value_mem[value_depth];
        // leaving value equal to the peak retires that peak
        if (peak_depth != 0 && r.popped_value == peak_mem[peak_depth-1]) begin
          peak_depth--;
        end
      end
    end
    r.max_valid   = (value_depth != 0 && peak_depth != 0);
    r.current_max = r.max_valid ? peak_mem[peak_depth-1] : '0;
    r.is_empty    = (value_depth == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                             input logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // predict on input accept, compare on output accept
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      value_depth = 0;
      peak_depth  = 0;
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(next_result(operation, push_value));
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result word arrived with no word expected");
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("popped_value", want.popped_value, popped_value);
          check_field("current_max", want.current_max, current_max);
          check_field("max_valid", data_t'(want.max_valid), data_t'(max_valid));
          check_field("is_empty", data_t'(want.is_empty), data_t'(is_empty));
          check_field("error_code", data_t'(want.error_code), data_t'(error_code));
        end
      end
    end
    pending <= result_q.size();
  end

endmodule

[dv/max_tracking_stack_test.sv]
`timescale 1ns / 1ps
// testbench top for the max tracking stack: stimulus, flow control and verdict
module max_tracking_stack_test;
  import mts_pkg::*;

  localparam int    RANDOM_WORDS = 400;
  localparam int    TAIL_WORDS   = 40;
  localparam int    HOLD_AT      = 100;
  localparam int    HOLD_CYCLES  = 200;
  localparam int    DRAIN_CYCLES = 20;
  localparam data_t MAX_WORD     = data_t'(32'h7fff_ffff);
  localparam data_t MIN_WORD     = data_t'(32'h8000_0000);

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       operation = OP_PUSH;
  data_t      push_value = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  data_t      popped_value;
  data_t      current_max;
  logic       max_valid;
  logic       is_empty;
  logic [1:0] error_code;
  int         fail_count;
  int         pending;

  bit         idle_on = 1'b0;
  int         n_sent = 0;

  max_tracking_stack uut (.*);

  max_tracking_stack_check checker_i (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one word, with an optional idle burst before it
  task automatic send_word(input logic op, input data_t word_value);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    push_value <= word_value;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // mix of full range values, extremes and small values that tie often
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return data_t'($urandom);
      4, 5, 6:    return data_t'($urandom_range(0, 8)) - 4;
      7:          return MAX_WORD;
      8:          return MIN_WORD;
      default:    return data_t'($urandom_range(0, 1)) - 1;
    endcase
  endfunction

  task automatic send_random(input int push_pct);
    if ($urandom_range(0, 99) < push_pct) send_word(OP_PUSH, pick_value());
    else send_word(OP_POP, data_t'($urandom));
  endtask

  // stop offering until every expected word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: one long hold-off, otherwise short random stalls
  initial begin : receiver
    int burst;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int walk_len;
    int push_pct;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_on = 1'b1;

    // pop on empty, value field ignored on pop
    send_word(OP_POP, '0);
    send_word(OP_POP, data_t'(32'h1234_5678));
    // extremes, a tie at the top, then unwind
    send_word(OP_PUSH, MAX_WORD);
    send_word(OP_PUSH, MIN_WORD);
    send_word(OP_PUSH, '0);
    send_word(OP_PUSH, data_t'(-1));
    send_word(OP_PUSH, MAX_WORD);
    send_word(OP_PUSH, data_t'(5));
    repeat (6) send_word(OP_POP, data_t'($urandom));
    send_word(OP_POP, MAX_WORD);
    // negative peaks with a tie below a lower value
    send_word(OP_PUSH, data_t'(-5));
    send_word(OP_PUSH, data_t'(-7));
    send_word(OP_PUSH, data_t'(-5));
    send_word(OP_PUSH, data_t'(-6));
    repeat (4) send_word(OP_POP, '0);
    send_word(OP_POP, MIN_WORD);
    drain_results();

    // fill past full, then unwind past empty
    repeat (STACK_DEPTH + 4) send_word(OP_PUSH, pick_value());
    repeat (STACK_DEPTH + 4) send_word(OP_POP, data_t'($urandom));

    // random walks with varying push bias and idling
    while (n_sent < RANDOM_WORDS) begin
      idle_on  = ($urandom_range(0, 2) != 0);
      push_pct = $urandom_range(25, 75);
      walk_len = $urandom_range(15, 40);
      repeat (walk_len) send_random(push_pct);
    end

    // closing stretch at full rate
    idle_on = 1'b0;
    repeat (TAIL_WORDS) send_random(50);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/mts_pkg.sv
sv/mts_out_buf.sv
sv/max_tracking_stack.sv
dv/max_tracking_stack_check.sv
dv/max_tracking_stack_test.sv
